// ----- hw/rtl/sca_pkg.sv -----
// Shared constants, types and status codes for the slab chunk allocator.
// Used by sca_div and slab_chunk_allocator; depends on nothing else.
`timescale 1ns / 1ps

package sca_pkg;

  localparam int MEM_BYTES       = 4096;
  localparam int SLAB_COUNT      = 8;
  localparam int MIN_CHUNK_BYTES = 8;

  localparam int SLAB_BYTES = MEM_BYTES / SLAB_COUNT;
  localparam int MAX_CHUNKS = SLAB_BYTES / MIN_CHUNK_BYTES;
  localparam int LINK_DEPTH = SLAB_COUNT * MAX_CHUNKS;

  localparam int OP_W       = 1;
  localparam int REQ_W      = 16;
  localparam int OFF_W      = 12;
  localparam int ST_W       = 3;
  localparam int OUT_SLAB_W = 3;

  localparam int SLAB_W  = (SLAB_COUNT > 1) ? $clog2(SLAB_COUNT) : 1;
  localparam int SIZE_W  = $clog2(SLAB_BYTES + 1);
  localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
  localparam int REL_W   = $clog2(SLAB_BYTES);
  localparam int LINK_AW = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
  localparam int MEM_W   = $clog2(MEM_BYTES + 1);
  localparam int ADDR_W  = (MEM_W > OFF_W) ? MEM_W : OFF_W;
  localparam int PROD_W  = CNT_W + SIZE_W;
  localparam int DCNT_W  = $clog2(REL_W + 1);

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 3'd0,
    ST_EXHAUSTED  = 3'd1,
    ST_NO_SLAB    = 3'd2,
    ST_BAD_SIZE   = 3'd3,
    ST_BAD_OFFSET = 3'd4
  } status_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  fresh;
    logic [CNT_W-1:0]  head;
  } slab_ent_t;

  typedef struct packed {
    logic              start;
    logic [REL_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [REL_W-1:0]  quo;
    logic [SIZE_W-1:0] rem;
  } div_res_t;

endpackage

// ----- hw/rtl/sca_div.sv -----
// Restoring divider, one quotient bit per cycle, for offset-in-slab by chunk size.
// Depends on sca_pkg for widths and the request and result structs.
`timescale 1ns / 1ps

module sca_div
  import sca_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_res_t res
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [REL_W-1:0]  quo_r;
  logic [SIZE_W-1:0] rem_r;
  logic [SIZE_W-1:0] dvs_r;
  logic [SIZE_W:0]   trial;
  logic              take;
  logic [SIZE_W-1:0] rem_step;

  always_comb begin
    trial    = {rem_r, quo_r[REL_W-1]};
    take     = (trial >= {1'b0, dvs_r});
    rem_step = take ? SIZE_W'(trial - {1'b0, dvs_r}) : trial[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == DCNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(REL_W);
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_step;
        quo_r <= {quo_r[REL_W-2:0], take};
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

// ----- hw/rtl/slab_chunk_allocator.sv -----
// Slab chunk allocator top level: slab table and chunk link memories with the sequencer.
// Depends on sca_pkg and instantiates sca_div.
`timescale 1ns / 1ps

// One word in, one word out, one word at a time. An allocate scans the slab table
// one entry per cycle, looking at 1 to SLAB_COUNT slabs. A free walks the slabs to find
// its own, one per cycle, then divides the in-slab offset by the chunk size one bit per
// cycle. A bad size is answered without a scan. A finished result sits in the output
// register so the next word can be accepted before the result is taken.

module slab_chunk_allocator
  import sca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [REQ_W-1:0]      in_request_size,
  input  logic [OFF_W-1:0]      in_chunk_offset,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ST_W-1:0]       out_status,
  output logic [OFF_W-1:0]      out_result_offset,
  output logic [OUT_SLAB_W-1:0] out_slab_number
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_TAKE, S_LINK, S_FRESH, S_MUL, S_ADDR,
    S_FMAP, S_FSLAB, S_FDIV, S_EMIT
  } state_t;

  localparam logic [SLAB_W-1:0] LAST_SLAB = SLAB_W'(SLAB_COUNT - 1);
  localparam logic [CNT_W-1:0]  EMPTY     = CNT_W'(MAX_CHUNKS);

  state_t             st_r;
  logic [SIZE_W-1:0]  req_size_r;
  logic [OFF_W-1:0]   off_r;
  logic [SLAB_W-1:0]  s_r;
  logic [ADDR_W-1:0]  base_r;
  logic [REL_W-1:0]   rel_r;
  slab_ent_t          ent_r;
  logic [CNT_W-1:0]   idx_r;
  logic [PROD_W-1:0]  prod_r;
  status_t            rs_status_r;
  logic [OFF_W-1:0]   rs_off_r;
  logic               slab_wr_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [OFF_W-1:0]   out_off_r;
  logic [OUT_SLAB_W-1:0] out_slab_r;

  slab_ent_t          slab_mem [SLAB_COUNT];
  logic [SLAB_COUNT-1:0] slab_vld_r;
  slab_ent_t          slab_q_r;
  logic               slab_q_vld_r;
  logic [SLAB_W-1:0]  slab_rd_addr;
  logic               slab_we;

  logic [CNT_W-1:0]   link_mem [LINK_DEPTH];
  logic [CNT_W-1:0]   link_q_r;
  logic               link_re;
  logic [LINK_AW-1:0] link_rd_addr;
  logic               link_we;
  logic [LINK_AW-1:0] link_wr_addr;

  slab_ent_t          eff;
  logic               out_free;
  logic               bad_size;
  logic               free_ok;
  logic [ADDR_W:0]    slab_top;
  div_req_t           div_req;
  div_res_t           div_res;

  sca_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  always_comb begin
    eff = slab_q_vld_r ? slab_q_r : '{size: '0, fresh: '0, head: EMPTY};
    out_free = !out_valid_r || out_ready;
    bad_size = (in_request_size == '0)
            || (32'(in_request_size) < 32'(MIN_CHUNK_BYTES))
            || (32'(in_request_size) > 32'(SLAB_BYTES));
    slab_top = (ADDR_W+1)'(base_r) + (ADDR_W+1)'(SLAB_BYTES);
    free_ok  = (div_res.rem == '0)
            && ((SIZE_W+1)'(rel_r) + (SIZE_W+1)'(ent_r.size) <= (SIZE_W+1)'(SLAB_BYTES))
            && (32'(div_res.quo) < 32'(MAX_CHUNKS));

    unique case (st_r)
      S_SCAN:  slab_rd_addr = (s_r == LAST_SLAB) ? s_r : s_r + SLAB_W'(1);
      S_FMAP:  slab_rd_addr = s_r;
      default: slab_rd_addr = '0;
    endcase
    slab_we = (st_r == S_EMIT) && out_free && slab_wr_r;

    link_re      = (st_r == S_TAKE) && (ent_r.head < EMPTY);
    link_rd_addr = LINK_AW'(LINK_AW'(s_r) * LINK_AW'(MAX_CHUNKS) + LINK_AW'(ent_r.head));
    link_we      = (st_r == S_FDIV) && div_res.done && free_ok;
    link_wr_addr = LINK_AW'(LINK_AW'(s_r) * LINK_AW'(MAX_CHUNKS) + LINK_AW'(div_res.quo));

    div_req.start    = (st_r == S_FSLAB) && (eff.size != '0);
    div_req.dividend = rel_r;
    div_req.divisor  = eff.size;
  end

  always_ff @(posedge clk) begin
    slab_q_r <= slab_mem[slab_rd_addr];
    if (slab_we) begin
      slab_mem[s_r] <= ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slab_vld_r   <= '0;
      slab_q_vld_r <= 1'b0;
    end else begin
      slab_q_vld_r <= slab_vld_r[slab_rd_addr];
      if (slab_we) begin
        slab_vld_r[s_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_re) begin
      link_q_r <= link_mem[link_rd_addr];
    end
    if (link_we) begin
      link_mem[link_wr_addr] <= ent_r.head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      slab_wr_r   <= 1'b0;
    end else begin
      if ((st_r == S_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            s_r       <= '0;
            base_r    <= '0;
            off_r     <= in_chunk_offset;
            rs_off_r  <= '0;
            slab_wr_r <= 1'b0;
            if (in_opcode == OP_ALLOC) begin
              req_size_r <= SIZE_W'(in_request_size);
              if (bad_size) begin
                rs_status_r <= ST_BAD_SIZE;
                st_r        <= S_EMIT;
              end else begin
                st_r <= S_SCAN;
              end
            end else if (32'(in_chunk_offset) >= 32'(MEM_BYTES)) begin
              rs_status_r <= ST_BAD_OFFSET;
              st_r        <= S_EMIT;
            end else begin
              st_r <= S_FMAP;
            end
          end
        end
        S_SCAN: begin
          if (eff.size == req_size_r) begin
            ent_r <= eff;
            st_r  <= S_TAKE;
          end else if (eff.size == '0) begin
            ent_r <= '{size: req_size_r, fresh: '0, head: EMPTY};
            st_r  <= S_TAKE;
          end else if (s_r == LAST_SLAB) begin
            s_r         <= '0;
            rs_status_r <= ST_NO_SLAB;
            st_r        <= S_EMIT;
          end else begin
            s_r <= s_r + SLAB_W'(1);
          end
        end
        S_TAKE: begin
          slab_wr_r <= 1'b1;
          if (ent_r.head < EMPTY) begin
            idx_r <= ent_r.head;
            st_r  <= S_LINK;
          end else begin
            idx_r  <= ent_r.fresh;
            prod_r <= PROD_W'(PROD_W'(ent_r.fresh) + PROD_W'(1)) * PROD_W'(ent_r.size);
            st_r   <= S_FRESH;
          end
        end
        S_LINK: begin
          ent_r.head <= (link_q_r > EMPTY) ? EMPTY : link_q_r;
          st_r       <= S_MUL;
        end
        S_FRESH: begin
          if (prod_r <= PROD_W'(SLAB_BYTES)) begin
            ent_r.fresh <= ent_r.fresh + CNT_W'(1);
            st_r        <= S_MUL;
          end else begin
            rs_status_r <= ST_EXHAUSTED;
            st_r        <= S_EMIT;
          end
        end
        S_MUL: begin
          prod_r <= PROD_W'(idx_r) * PROD_W'(ent_r.size);
          base_r <= ADDR_W'(ADDR_W'(s_r) * ADDR_W'(SLAB_BYTES));
          st_r   <= S_ADDR;
        end
        S_ADDR: begin
          rs_off_r    <= OFF_W'(base_r + ADDR_W'(prod_r));
          rs_status_r <= ST_OK;
          st_r        <= S_EMIT;
        end
        S_FMAP: begin
          if ((ADDR_W+1)'(off_r) >= slab_top) begin
            if (s_r == LAST_SLAB) begin
              s_r         <= '0;
              rs_status_r <= ST_BAD_OFFSET;
              st_r        <= S_EMIT;
            end else begin
              s_r    <= s_r + SLAB_W'(1);
              base_r <= ADDR_W'(slab_top);
            end
          end else begin
            rel_r <= REL_W'(ADDR_W'(off_r) - base_r);
            st_r  <= S_FSLAB;
          end
        end
        S_FSLAB: begin
          ent_r <= eff;
          if (eff.size == '0) begin
            rs_status_r <= ST_BAD_OFFSET;
            st_r        <= S_EMIT;
          end else begin
            st_r <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_res.done) begin
            if (free_ok) begin
              ent_r.head  <= CNT_W'(div_res.quo);
              slab_wr_r   <= 1'b1;
              rs_status_r <= ST_OK;
            end else begin
              rs_status_r <= ST_BAD_OFFSET;
            end
            st_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_status_r <= rs_status_r;
            out_off_r    <= rs_off_r;
            out_slab_r   <= OUT_SLAB_W'(s_r);
            st_r         <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready          = (st_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_offset = out_off_r;
  assign out_slab_number   = out_slab_r;

endmodule

// ----- verif/slab_chunk_allocator_test.sv -----
// Self-checking testbench for slab_chunk_allocator: directed and random allocate/free words.
// A scoreboard class predicts every reply; depends on sca_pkg and the allocator RTL.
`timescale 1ns / 1ps

module slab_chunk_allocator_test;
  import sca_pkg::*;

  typedef struct packed {
    status_t               status;
    logic [OFF_W-1:0]      offset;
    logic [OUT_SLAB_W-1:0] slab;
  } alloc_reply_t;

  class alloc_scoreboard;
    logic [SIZE_W-1:0] chunk_size [SLAB_COUNT];
    logic [CNT_W-1:0]  fresh_count [SLAB_COUNT];
    logic [CNT_W-1:0]  free_head [SLAB_COUNT];
    logic [CNT_W-1:0]  chunk_link [LINK_DEPTH];
    alloc_reply_t      pending [$];
    logic [OFF_W-1:0]  live_chunks [$];
    int                errors;
    int                checked;

    function new();
      for (int s = 0; s < SLAB_COUNT; s++) begin
        chunk_size[s]  = '0;
        fresh_count[s] = '0;
        free_head[s]   = CNT_W'(MAX_CHUNKS);
      end
      errors  = 0;
      checked = 0;
    endfunction

    function alloc_reply_t take_chunk(int s);
      alloc_reply_t r;
      int idx;
      r = '{status: ST_EXHAUSTED, offset: '0, slab: s[OUT_SLAB_W-1:0]};
      if (free_head[s] < MAX_CHUNKS) begin
        idx = int'(free_head[s]);
        free_head[s] = chunk_link[s * MAX_CHUNKS + idx];
      end else if (fresh_count[s] < SLAB_BYTES / chunk_size[s]) begin
        idx = int'(fresh_count[s]);
        fresh_count[s] = fresh_count[s] + 1'b1;
      end else begin
        return r;
      end
      r.status = ST_OK;
      r.offset = OFF_W'(s * SLAB_BYTES + idx * chunk_size[s]);
      live_chunks.push_back(r.offset);
      return r;
    endfunction

    function alloc_reply_t predict_alloc(logic [REQ_W-1:0] size);
      alloc_reply_t r;
      r = '{status: ST_BAD_SIZE, offset: '0, slab: '0};
      if (size < MIN_CHUNK_BYTES || size > SLAB_BYTES) return r;
      r.status = ST_NO_SLAB;
      for (int s = 0; s < SLAB_COUNT; s++) begin
        if (chunk_size[s] == size) return take_chunk(s);
        if (chunk_size[s] == 0) begin
          chunk_size[s]  = SIZE_W'(size);
          fresh_count[s] = '0;
          free_head[s]   = CNT_W'(MAX_CHUNKS);
          return take_chunk(s);
        end
      end
      return r;
    endfunction

    function alloc_reply_t predict_free(logic [OFF_W-1:0] off);
      alloc_reply_t r;
      int s;
      int rel;
      int csize;
      int idx;
      s     = off / SLAB_BYTES;
      rel   = off % SLAB_BYTES;
      r     = '{status: ST_BAD_OFFSET, offset: '0, slab: s[OUT_SLAB_W-1:0]};
      csize = int'(chunk_size[s]);
      if (csize == 0) return r;
      idx = rel / csize;
      if (rel % csize != 0 || idx >= SLAB_BYTES / csize || idx >= MAX_CHUNKS) return r;
      chunk_link[s * MAX_CHUNKS + idx] = free_head[s];
      free_head[s] = CNT_W'(idx);
      r.status = ST_OK;
      return r;
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [REQ_W-1:0] size,
                             logic [OFF_W-1:0] off);
      if (op == OP_ALLOC) pending.push_back(predict_alloc(size));
      else pending.push_back(predict_free(off));
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(logic [ST_W-1:0] st, logic [OFF_W-1:0] off,
                      logic [OUT_SLAB_W-1:0] slab);
      alloc_reply_t want;
      checked++;
      if (pending.size() == 0) begin
        report("reply word with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (st !== want.status)
        report($sformatf("status got %0d want %0d", st, want.status));
      if (off !== want.offset)
        report($sformatf("result_offset got %0d want %0d", off, want.offset));
      if (slab !== want.slab)
        report($sformatf("slab_number got %0d want %0d", slab, want.slab));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [OP_W-1:0]       in_opcode;
  logic [REQ_W-1:0]      in_request_size;
  logic [OFF_W-1:0]      in_chunk_offset;
  logic                  out_valid;
  logic                  out_ready;
  logic [ST_W-1:0]       out_status;
  logic [OFF_W-1:0]      out_result_offset;
  logic [OUT_SLAB_W-1:0] out_slab_number;

  alloc_scoreboard sb = new();

  slab_chunk_allocator DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_request_size   (in_request_size),
    .in_chunk_offset   (in_chunk_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_result_offset (out_result_offset),
    .out_slab_number   (out_slab_number)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      sb.check_result(out_status, out_result_offset, out_slab_number);
  end

  task send_word(logic [OP_W-1:0] op, logic [REQ_W-1:0] size, logic [OFF_W-1:0] off);
    in_opcode       = op;
    in_request_size = size;
    in_chunk_offset = off;
    in_valid        = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_input(op, size, off);
    @(negedge clk);
  endtask

  task idle_sender(int cycles);
    in_valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task wait_drained();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task make_word(int alloc_pct, output logic [OP_W-1:0] op,
                 output logic [REQ_W-1:0] size, output logic [OFF_W-1:0] off);
    int k;
    int s;
    int i;
    int csize;
    size = REQ_W'($urandom_range(0, 65535));
    off  = OFF_W'($urandom_range(0, 4095));
    k    = $urandom_range(0, 19);
    if ($urandom_range(0, 99) < alloc_pct) begin
      op = OP_ALLOC;
      if (k == 1) size = REQ_W'($urandom_range(MIN_CHUNK_BYTES, SLAB_BYTES));
      else if (k > 1) size = REQ_W'(sb.chunk_size[$urandom_range(0, SLAB_COUNT - 1)]);
    end else begin
      op = OP_FREE;
      if (k < 15 && sb.live_chunks.size() > 0) begin
        i   = $urandom_range(0, sb.live_chunks.size() - 1);
        off = sb.live_chunks[i];
        if (k != 0) sb.live_chunks.delete(i);
      end else if (k < 18) begin
        s     = $urandom_range(0, SLAB_COUNT - 1);
        csize = int'(sb.chunk_size[s]);
        if (csize != 0)
          off = OFF_W'(s * SLAB_BYTES + $urandom_range(0, SLAB_BYTES / csize - 1) * csize);
      end
    end
  endtask

  initial begin
    int receiver_mode;
    int mode_left;
    bit held;
    out_ready     = 1'b0;
    receiver_mode = 0;
    mode_left     = 0;
    held          = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sb.checked >= 400) begin
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
      end
      if (mode_left == 0) begin
        receiver_mode = $urandom_range(0, 2);
        mode_left     = $urandom_range(16, 96);
      end
      mode_left--;
      case (receiver_mode)
        0: out_ready = 1'b1;
        1: out_ready = 1'($urandom_range(0, 1));
        default: out_ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [OP_W-1:0]  op;
    logic [REQ_W-1:0] size;
    logic [OFF_W-1:0] off;
    int alloc_pct;
    int burst_left;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = OP_ALLOC;
    in_request_size = '0;
    in_chunk_offset = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_word(OP_ALLOC, 16'd0, 12'd0);
    send_word(OP_ALLOC, 16'd7, 12'd0);
    send_word(OP_ALLOC, 16'd513, 12'd0);
    send_word(OP_ALLOC, 16'd65535, 12'd0);
    send_word(OP_FREE, 16'd0, 12'd0);
    send_word(OP_FREE, 16'd0, 12'd4095);
    send_word(OP_ALLOC, 16'd512, 12'd0);
    send_word(OP_ALLOC, 16'd512, 12'd0);
    send_word(OP_FREE, 16'd0, 12'd0);
    send_word(OP_FREE, 16'd0, 12'd0);
    send_word(OP_ALLOC, 16'd512, 12'd0);
    send_word(OP_ALLOC, 16'd512, 12'd0);
    send_word(OP_ALLOC, 16'd512, 12'd0);
    send_word(OP_ALLOC, 16'd8, 12'd0);
    send_word(OP_FREE, 16'd0, 12'd516);
    send_word(OP_ALLOC, 16'd24, 12'd0);
    send_word(OP_FREE, 16'd0, 12'd1528);
    send_word(OP_FREE, 16'd0, 12'd1048);
    send_word(OP_ALLOC, 16'd100, 12'd0);
    send_word(OP_ALLOC, 16'd9, 12'd0);
    send_word(OP_ALLOC, 16'd256, 12'd0);
    send_word(OP_ALLOC, 16'd64, 12'd0);
    send_word(OP_ALLOC, 16'd500, 12'd0);
    send_word(OP_ALLOC, 16'd16, 12'd0);
    send_word(OP_FREE, 16'd0, 12'd512);
    wait_drained();

    burst_left = 0;
    for (int phase = 0; phase < 7; phase++) begin
      alloc_pct = $urandom_range(20, 80);
      for (int i = 0; i < 250; i++) begin
        if (burst_left == 0) begin
          idle_sender($urandom_range(1, 8));
          burst_left = $urandom_range(1, 40);
        end
        make_word(alloc_pct, op, size, off);
        send_word(op, size, off);
        burst_left--;
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
